FILE: rtl/pid_rate_feedforward_step_assert.svh
// Assertion macros for the PID rate-feedforward step block.
// Needs nothing else; define NO_ASSERTIONS to compile them out.
`ifndef PID_RATE_FEEDFORWARD_STEP_ASSERT_SVH
`define PID_RATE_FEEDFORWARD_STEP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define PRFS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PRFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PRFS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define PRFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/prfs_pkg.sv
// Shared types, constants and the microcode program of the PID step block.
// No dependencies.
`default_nettype none

package prfs_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int STEP_W         = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP         = 3'd0,
        CFG_KI_HALF    = 3'd1,
        CFG_KD         = 3'd2,
        CFG_RATE_SCALE = 3'd3,
        CFG_ACCUM_MIN  = 3'd4,
        CFG_ACCUM_MAX  = 3'd5,
        CFG_OUTPUT_MIN = 3'd6,
        CFG_OUTPUT_MAX = 3'd7
    } cfg_idx_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,    // latch the sample
        OP_ERR,     // err = sat(setpoint - measurement)
        OP_ASUM,    // sum = accum + err + last err
        OP_ACLMP,   // accum = clamp(sum), last err = err, sum = 0
        OP_DSP,     // tmp = sat(setpoint - last setpoint), last setpoint = setpoint
        OP_MLO,     // prod = a * low half of b
        OP_MHI,     // prod += a * high half of b, shifted
        OP_TACC,    // sum += term
        OP_TSUB,    // tmp = sat(term - measurement rate)
        OP_OUT      // drive = clamp(sum)
    } op_t;

    typedef enum logic [1:0] {
        A_KP,
        A_KI,
        A_KD,
        A_RATE
    } asel_t;

    typedef enum logic [1:0] {
        B_ERR,
        B_EACC,
        B_TMP
    } bsel_t;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_SAMPLE,
        COND_SLOT
    } cond_t;

    typedef struct packed {
        op_t               op;
        asel_t             asel;
        bsel_t             bsel;
        cond_t             cond;
        logic              jump;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        ctrl_t cw;
        logic  go;
    } issue_t;

    function automatic ctrl_t prfs_word(input op_t op, input asel_t asel, input bsel_t bsel,
                                        input cond_t cond, input logic jump);
        ctrl_t w;
        w.op     = op;
        w.asel   = asel;
        w.bsel   = bsel;
        w.cond   = cond;
        w.jump   = jump;
        w.target = '0;
        return w;
    endfunction

    // Control store: one word per step.
    function automatic ctrl_t prfs_ucode(input logic [STEP_W-1:0] step);
        ctrl_t w;
        unique case (step)
            5'd0:    w = prfs_word(OP_LOAD,  A_KP,   B_ERR,  COND_SAMPLE, 1'b0);
            5'd1:    w = prfs_word(OP_ERR,   A_KP,   B_ERR,  COND_ALWAYS, 1'b0);
            5'd2:    w = prfs_word(OP_ASUM,  A_KP,   B_ERR,  COND_ALWAYS, 1'b0);
            5'd3:    w = prfs_word(OP_ACLMP, A_KP,   B_ERR,  COND_ALWAYS, 1'b0);
            5'd4:    w = prfs_word(OP_DSP,   A_KP,   B_ERR,  COND_ALWAYS, 1'b0);
            5'd5:    w = prfs_word(OP_MLO,   A_KP,   B_ERR,  COND_ALWAYS, 1'b0);
            5'd6:    w = prfs_word(OP_MHI,   A_KP,   B_ERR,  COND_ALWAYS, 1'b0);
            5'd7:    w = prfs_word(OP_TACC,  A_KP,   B_ERR,  COND_ALWAYS, 1'b0);
            5'd8:    w = prfs_word(OP_MLO,   A_KI,   B_EACC, COND_ALWAYS, 1'b0);
            5'd9:    w = prfs_word(OP_MHI,   A_KI,   B_EACC, COND_ALWAYS, 1'b0);
            5'd10:   w = prfs_word(OP_TACC,  A_KI,   B_EACC, COND_ALWAYS, 1'b0);
            5'd11:   w = prfs_word(OP_MLO,   A_RATE, B_TMP,  COND_ALWAYS, 1'b0);
            5'd12:   w = prfs_word(OP_MHI,   A_RATE, B_TMP,  COND_ALWAYS, 1'b0);
            5'd13:   w = prfs_word(OP_TSUB,  A_RATE, B_TMP,  COND_ALWAYS, 1'b0);
            5'd14:   w = prfs_word(OP_MLO,   A_KD,   B_TMP,  COND_ALWAYS, 1'b0);
            5'd15:   w = prfs_word(OP_MHI,   A_KD,   B_TMP,  COND_ALWAYS, 1'b0);
            5'd16:   w = prfs_word(OP_TACC,  A_KD,   B_TMP,  COND_ALWAYS, 1'b0);
            5'd17:   w = prfs_word(OP_OUT,   A_KP,   B_ERR,  COND_SLOT,   1'b1);
            default: w = prfs_word(OP_NOP,   A_KP,   B_ERR,  COND_ALWAYS, 1'b1);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/pid_rate_feedforward_step.sv
// PID step with trapezoidal integral, setpoint-rate feedforward and output clamp.
// A sample is taken at the load step and drive_valid is registered after the output
// step; samples do not overlap, as the 18-step microcode program runs around one
// shared multiplier (two partial-product passes per product).
// Reset clears the loop state and sets gains to zero and limits to full range.
// Depends on prfs_pkg, prfs_seq, prfs_dp and the assertion macro header.
`default_nettype none

`include "pid_rate_feedforward_step_assert.svh"

module pid_rate_feedforward_step
    import prfs_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [DATA_WIDTH-1:0] cfg_data,
    input  wire logic                  sample_valid,
    output logic                       sample_stall,
    input  wire logic [DATA_WIDTH-1:0] setpoint,
    input  wire logic [DATA_WIDTH-1:0] measurement,
    input  wire logic [DATA_WIDTH-1:0] measurement_rate,
    output logic                       drive_valid,
    input  wire logic                  drive_stall,
    output logic      [DATA_WIDTH-1:0] drive_out
);

    issue_t issue;
    logic   slot_free;
    logic   drive_valid_reg;
    logic   out_fire;

    assign slot_free    = !drive_valid_reg || !drive_stall;
    assign out_fire     = issue.go && issue.cw.op == OP_OUT;
    assign sample_stall = issue.cw.cond != COND_SAMPLE;
    assign drive_valid  = drive_valid_reg;

    prfs_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .slot_free    (slot_free),
        .issue        (issue)
    );

    prfs_dp #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .setpoint         (setpoint),
        .measurement      (measurement),
        .measurement_rate (measurement_rate),
        .issue            (issue),
        .drive_out        (drive_out)
    );

    // hold the beat until taken; a new result may replace it in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            drive_valid_reg <= 1'b0;
        else if (out_fire)
            drive_valid_reg <= 1'b1;
        else if (!drive_stall)
            drive_valid_reg <= 1'b0;
    end

    `PRFS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, sample_valid && !sample_stall, sample_stall, "sample taken while previous one in flight")
    `PRFS_ASSERT_IMPLY(a_out_into_free_slot, clk, rst_n, out_fire, !drive_valid_reg || !drive_stall, "result overwrote a stalled beat")
    `PRFS_ASSERT_IMPLY(a_valid_from_out_step, clk, rst_n, $rose(drive_valid_reg), $past(out_fire), "drive_valid rose without an output step")

endmodule

`default_nettype wire

FILE: rtl/prfs_seq.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on prfs_pkg.
`default_nettype none

module prfs_seq
    import prfs_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   sample_valid,
    input  wire logic   slot_free,
    output issue_t      issue
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ctrl_t             cw;
    logic              go;

    always_comb
    begin
        cw = prfs_ucode(step_reg);
        unique case (cw.cond)
            COND_ALWAYS: go = 1'b1;
            COND_SAMPLE: go = sample_valid;
            COND_SLOT:   go = slot_free;
            default:     go = 1'b0;
        endcase
        if (!go)
            step_next = step_reg;
        else if (cw.jump)
            step_next = cw.target;
        else
            step_next = step_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else
            step_reg <= step_next;
    end

    assign issue = '{cw: cw, go: go};

endmodule

`default_nettype wire

FILE: rtl/prfs_dp.sv
// Datapath: configuration registers, loop state, shared multiplier,
// saturating subtractor, clamp unit and the drive output register. Depends on prfs_pkg.
`default_nettype none

module prfs_dp
    import prfs_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [DATA_WIDTH-1:0] cfg_data,
    input  wire logic [DATA_WIDTH-1:0] setpoint,
    input  wire logic [DATA_WIDTH-1:0] measurement,
    input  wire logic [DATA_WIDTH-1:0] measurement_rate,
    input  wire issue_t                issue,
    output logic      [DATA_WIDTH-1:0] drive_out
);

    localparam int W  = DATA_WIDTH;
    localparam int H  = (W + 1) / 2;     // low half of the b operand
    localparam int PW = W + H + 1;       // partial product width
    localparam int SW = W + 2;           // three-term sum width
    localparam int TW = 2 * W - FRAC_BITS;

    localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};

    // configuration
    logic [W-1:0] kp_reg, ki_reg, kd_reg;
    logic [W-2:0] rate_reg;
    logic [W-1:0] amin_reg, amax_reg, omin_reg, omax_reg;

    // loop state
    logic [W-1:0] eacc_reg, lerr_reg, lsp_reg;

    // per-sample working registers
    logic [W-1:0]   sp_reg, meas_reg, mrate_reg;
    logic [W-1:0]   err_reg, tmp_reg, drive_reg;
    logic [2*W-1:0] prod_reg;
    logic [SW-1:0]  sum_reg;

    logic              run;
    op_t               op;
    logic signed [W-1:0]  a_op;
    logic        [W-1:0]  b_op;
    logic signed [H:0]    b_part;
    logic signed [PW-1:0] pp;
    logic [2*W-1:0]       pp_ext;
    logic [TW-1:0]        shifted;
    logic                 term_ovf;
    logic [W-1:0]         term;
    logic [W-1:0]         sub_a, sub_b;
    logic [W:0]           diff;
    logic [W-1:0]         diff_sat;
    logic signed [SW-1:0] lo_x, hi_x, clamp_lo, clamp_hi;
    logic [W-1:0]         clamped;
    logic [SW-1:0]        three_sum;

    assign run = issue.go;
    assign op  = issue.cw.op;

    // multiplier operands
    always_comb
    begin
        case (issue.cw.asel)
            A_KP:    a_op = kp_reg;
            A_KI:    a_op = ki_reg;
            A_KD:    a_op = kd_reg;
            default: a_op = {1'b0, rate_reg};
        endcase
        case (issue.cw.bsel)
            B_ERR:   b_op = err_reg;
            B_EACC:  b_op = eacc_reg;
            default: b_op = tmp_reg;
        endcase
        if (op == OP_MHI)
            b_part = {{(2*H+1-W){b_op[W-1]}}, b_op[W-1:H]};
        else
            b_part = {1'b0, b_op[H-1:0]};
    end

    assign pp     = a_op * b_part;
    assign pp_ext = {{(W-H-1){pp[PW-1]}}, pp};

    // floor shift of the product, then saturate
    assign shifted  = prod_reg[2*W-1:FRAC_BITS];
    assign term_ovf = !((&shifted[TW-1:W-1]) || !(|shifted[TW-1:W-1]));
    assign term     = term_ovf ? (shifted[TW-1] ? VMIN : VMAX) : shifted[W-1:0];

    // shared saturating subtractor
    always_comb
    begin
        case (op)
            OP_ERR:
            begin
                sub_a = sp_reg;
                sub_b = meas_reg;
            end
            OP_DSP:
            begin
                sub_a = sp_reg;
                sub_b = lsp_reg;
            end
            default:
            begin
                sub_a = term;
                sub_b = mrate_reg;
            end
        endcase
    end

    assign diff     = {sub_a[W-1], sub_a} - {sub_b[W-1], sub_b};
    assign diff_sat = (diff[W] != diff[W-1]) ? (diff[W] ? VMIN : VMAX) : diff[W-1:0];

    // shared clamp: lower limit first, upper limit wins when crossed
    always_comb
    begin
        if (op == OP_OUT)
        begin
            lo_x = {{2{omin_reg[W-1]}}, omin_reg};
            hi_x = {{2{omax_reg[W-1]}}, omax_reg};
        end
        else
        begin
            lo_x = {{2{amin_reg[W-1]}}, amin_reg};
            hi_x = {{2{amax_reg[W-1]}}, amax_reg};
        end
        clamp_lo = ($signed(sum_reg) < lo_x) ? lo_x : $signed(sum_reg);
        clamp_hi = (clamp_lo > hi_x) ? hi_x : clamp_lo;
        clamped  = clamp_hi[W-1:0];
    end

    assign three_sum = {{2{eacc_reg[W-1]}}, eacc_reg} + {{2{err_reg[W-1]}}, err_reg}
                     + {{2{lerr_reg[W-1]}}, lerr_reg};

    // configuration and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg   <= '0;
            ki_reg   <= '0;
            kd_reg   <= '0;
            rate_reg <= '0;
            amin_reg <= VMIN;
            amax_reg <= VMAX;
            omin_reg <= VMIN;
            omax_reg <= VMAX;
            eacc_reg <= '0;
            lerr_reg <= '0;
            lsp_reg  <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_KP:         kp_reg   <= cfg_data;
                    CFG_KI_HALF:    ki_reg   <= cfg_data;
                    CFG_KD:         kd_reg   <= cfg_data;
                    CFG_RATE_SCALE: rate_reg <= cfg_data[W-2:0];
                    CFG_ACCUM_MIN:  amin_reg <= cfg_data;
                    CFG_ACCUM_MAX:  amax_reg <= cfg_data;
                    CFG_OUTPUT_MIN: omin_reg <= cfg_data;
                    CFG_OUTPUT_MAX: omax_reg <= cfg_data;
                    default:        kp_reg   <= kp_reg;
                endcase
            end
            if (run && op == OP_ACLMP)
            begin
                eacc_reg <= clamped;
                lerr_reg <= err_reg;
            end
            if (run && op == OP_DSP)
                lsp_reg <= sp_reg;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (run)
        begin
            case (op)
                OP_LOAD:
                begin
                    sp_reg    <= setpoint;
                    meas_reg  <= measurement;
                    mrate_reg <= measurement_rate;
                end
                OP_ERR:   err_reg   <= diff_sat;
                OP_ASUM:  sum_reg   <= three_sum;
                OP_ACLMP: sum_reg   <= '0;
                OP_DSP:   tmp_reg   <= diff_sat;
                OP_MLO:   prod_reg  <= pp_ext;
                OP_MHI:   prod_reg  <= prod_reg + (pp_ext << H);
                OP_TACC:  sum_reg   <= sum_reg + {{2{term[W-1]}}, term};
                OP_TSUB:  tmp_reg   <= diff_sat;
                OP_OUT:   drive_reg <= clamped;
                default:  tmp_reg   <= tmp_reg;
            endcase
        end
    end

    assign drive_out = drive_reg;

endmodule

`default_nettype wire
